// ----- rtl/core/otgr_pkg.sv -----
// ----------------------------------------------------------------------------
// otgr_pkg
// Shared types, display command codes and the 5x7 glyph table of the text
// renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package otgr_pkg;

  // display command byte bases
  localparam logic [7:0] CMD_SET_PAGE   = 8'hB0;
  localparam logic [7:0] CMD_SET_COL_HI = 8'h10;
  localparam logic [7:0] CMD_SET_COL_LO = 8'h00;

  // edge limits and cursor advance
  localparam logic [7:0] COL_LIMIT_NORMAL = 8'd124;
  localparam logic [7:0] COL_LIMIT_DOUBLE = 8'd116;
  localparam logic [2:0] LAST_PAGE        = 3'd7;
  localparam logic [7:0] ADV_NORMAL       = 8'd6;
  localparam logic [7:0] ADV_DOUBLE       = 8'd12;

  // byte positions inside one page run: 3 commands, then data
  localparam logic [3:0] POS_FIRST_DATA  = 4'd3;
  localparam logic [3:0] POS_LAST_NORMAL = 4'd8;
  localparam logic [3:0] POS_LAST_DOUBLE = 4'd14;
  localparam logic [2:0] COL_BLANK       = 3'd5;

  localparam int JOBQ_DEPTH = 2;

  // five glyph columns, column 0 leftmost, bit 0 on top
  typedef logic [0:4][6:0] glyph_t;

  // one drawable character handed from front to back
  typedef struct packed {
    logic [6:0] col;
    logic [2:0] page;
    logic       dbl;
    glyph_t     glyph;
  } job_t;

  localparam glyph_t GLYPH_BOX = {7'h7F, 7'h00, 7'h00, 7'h00, 7'h7F};

  // font lookup, codes not in the font draw a box
  function automatic glyph_t glyph_lookup(input logic [7:0] code);
    glyph_t g;
    case (code)
      8'h20:   g = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
      8'h2D:   g = {7'h00, 7'h08, 7'h08, 7'h08, 7'h00};
      8'h2E:   g = {7'h00, 7'h00, 7'h60, 7'h60, 7'h00};
      8'h3A:   g = {7'h00, 7'h36, 7'h00, 7'h36, 7'h00};
      8'h30:   g = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
      8'h31:   g = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
      8'h32:   g = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
      8'h33:   g = {7'h21, 7'h41, 7'h45, 7'h4B, 7'h31};
      8'h34:   g = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
      8'h35:   g = {7'h27, 7'h45, 7'h45, 7'h45, 7'h39};
      8'h36:   g = {7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30};
      8'h37:   g = {7'h01, 7'h71, 7'h09, 7'h05, 7'h03};
      8'h38:   g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      8'h39:   g = {7'h06, 7'h49, 7'h49, 7'h29, 7'h1E};
      8'h41:   g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
      8'h43:   g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
      8'h44:   g = {7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C};
      8'h45:   g = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
      8'h46:   g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
      8'h48:   g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
      8'h49:   g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
      8'h4B:   g = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
      8'h4C:   g = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
      8'h4D:   g = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
      8'h4E:   g = {7'h7F, 7'h02, 7'h0C, 7'h10, 7'h7F};
      8'h4F:   g = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
      8'h50:   g = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
      8'h52:   g = {7'h7F, 7'h09, 7'h19, 7'h29, 7'h46};
      8'h53:   g = {7'h46, 7'h49, 7'h49, 7'h49, 7'h31};
      8'h54:   g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
      8'h55:   g = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
      8'h57:   g = {7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F};
      8'h58:   g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
      8'h59:   g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
      8'h5A:   g = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
      8'h61:   g = {7'h20, 7'h54, 7'h54, 7'h54, 7'h78};
      8'h63:   g = {7'h38, 7'h44, 7'h44, 7'h44, 7'h20};
      8'h64:   g = {7'h38, 7'h44, 7'h44, 7'h48, 7'h7F};
      8'h65:   g = {7'h38, 7'h54, 7'h54, 7'h54, 7'h18};
      8'h67:   g = {7'h08, 7'h54, 7'h54, 7'h54, 7'h3C};
      8'h68:   g = {7'h7F, 7'h08, 7'h04, 7'h04, 7'h78};
      8'h69:   g = {7'h00, 7'h44, 7'h7D, 7'h40, 7'h00};
      8'h6C:   g = {7'h00, 7'h41, 7'h7F, 7'h40, 7'h00};
      8'h6D:   g = {7'h7C, 7'h04, 7'h18, 7'h04, 7'h78};
      8'h6E:   g = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h78};
      8'h6F:   g = {7'h38, 7'h44, 7'h44, 7'h44, 7'h38};
      8'h70:   g = {7'h7C, 7'h14, 7'h14, 7'h14, 7'h08};
      8'h72:   g = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h08};
      8'h73:   g = {7'h48, 7'h54, 7'h54, 7'h54, 7'h20};
      8'h74:   g = {7'h04, 7'h3F, 7'h44, 7'h40, 7'h20};
      8'h75:   g = {7'h3C, 7'h40, 7'h40, 7'h20, 7'h7C};
      8'h76:   g = {7'h1C, 7'h20, 7'h40, 7'h20, 7'h1C};
      8'h78:   g = {7'h44, 7'h28, 7'h10, 7'h28, 7'h44};
      8'h79:   g = {7'h0C, 7'h50, 7'h50, 7'h50, 7'h3C};
      default: g = GLYPH_BOX;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/oled_text_glyph_renderer_core.sv -----
// ----------------------------------------------------------------------------
// oled_text_glyph_renderer_core
// Character string to display write transactions: cursor commands followed
// by glyph columns, normal 6x8 or doubled 12x16 cells.
// ----------------------------------------------------------------------------
// The front takes one character per cycle while its two-entry job queue has
// room; characters that draw nothing (string ended, zero code, past an edge)
// are consumed and emit no word. The back sequencer emits one word per
// cycle into a registered output while it is empty or popped, so a normal
// character takes 9 words and a doubled one 30; that byte counter sets the
// sustained character rate. Results are held in the output register while
// input continues into the queue as long as it has room.
`default_nettype none

module oled_text_glyph_renderer_core import otgr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_ch,
  input  wire logic [6:0] in_start_x,
  input  wire logic [2:0] in_start_page,
  input  wire logic       in_first,
  input  wire logic       in_double_size,
  input  wire logic       push,
  output logic            full,
  output logic [7:0]      out_byte,
  output logic            out_is_data,
  output logic            out_last,
  output logic            empty,
  input  wire logic       pop
);

  job_t front_job;
  job_t head_job;
  logic job_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic acc;

  assign full = q_full;
  assign acc  = push && !q_full;

  // front: cursor state and classification
  otgr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .ch          (in_ch),
    .start_x     (in_start_x),
    .start_page  (in_start_page),
    .first       (in_first),
    .double_size (in_double_size),
    .job         (front_job),
    .job_push    (job_push)
  );

  // job queue
  otgr_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_job  (front_job),
    .wr_en   (job_push),
    .q_full  (q_full),
    .rd_job  (head_job),
    .q_valid (q_valid),
    .rd_en   (q_pop)
  );

  // back: byte sequencer
  otgr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job         (head_job),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .out_byte    (out_byte),
    .out_is_data (out_is_data),
    .out_last    (out_last),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

`default_nettype wire

// ----- rtl/core/otgr_front.sv -----
// ----------------------------------------------------------------------------
// otgr_front
// Accepts characters, keeps the cursor and string state, drops characters
// that draw nothing and hands drawable ones with their glyph to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module otgr_front import otgr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [7:0] ch,
  input  wire logic [6:0] start_x,
  input  wire logic [2:0] start_page,
  input  wire logic       first,
  input  wire logic       double_size,
  output job_t            job,
  output logic            job_push
);

  logic [7:0] cursor_col_r, cursor_col_nxt;
  logic [2:0] cursor_row_r, cursor_row_nxt;
  logic       double_mode_r, double_mode_nxt;
  logic       string_ended_r, string_ended_nxt;

  logic [7:0] col_eff;
  logic [2:0] row_eff;
  logic       dbl_eff;
  logic       ended_eff;
  logic       at_edge;

  // state as seen after a possible string start
  always_comb begin
    col_eff   = first ? {1'b0, start_x} : cursor_col_r;
    row_eff   = first ? start_page : cursor_row_r;
    dbl_eff   = first ? double_size : double_mode_r;
    ended_eff = first ? 1'b0 : string_ended_r;
    at_edge   = dbl_eff ? ((col_eff >= COL_LIMIT_DOUBLE) || (row_eff == LAST_PAGE))
                        : (col_eff >= COL_LIMIT_NORMAL);
  end

  // classify the word and update the cursor
  always_comb begin
    cursor_col_nxt   = cursor_col_r;
    cursor_row_nxt   = cursor_row_r;
    double_mode_nxt  = double_mode_r;
    string_ended_nxt = string_ended_r;
    job_push         = 1'b0;
    if (acc) begin
      cursor_row_nxt   = row_eff;
      double_mode_nxt  = dbl_eff;
      cursor_col_nxt   = col_eff;
      string_ended_nxt = ended_eff;
      if (!ended_eff) begin
        if ((ch == 8'd0) || at_edge) begin
          string_ended_nxt = 1'b1;
        end else begin
          job_push       = 1'b1;
          cursor_col_nxt = col_eff + (dbl_eff ? ADV_DOUBLE : ADV_NORMAL);
        end
      end
    end
  end

  // job payload, col below the edge limit fits 7 bits
  always_comb begin
    job.col   = col_eff[6:0];
    job.page  = row_eff;
    job.dbl   = dbl_eff;
    job.glyph = glyph_lookup(ch);
  end

  // string state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r   <= '0;
      cursor_row_r   <= '0;
      double_mode_r  <= 1'b0;
      string_ended_r <= 1'b1;
    end else begin
      cursor_col_r   <= cursor_col_nxt;
      cursor_row_r   <= cursor_row_nxt;
      double_mode_r  <= double_mode_nxt;
      string_ended_r <= string_ended_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/otgr_jobq.sv -----
// ----------------------------------------------------------------------------
// otgr_jobq
// Short queue of drawable characters between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module otgr_jobq import otgr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire job_t wr_job,
  input  wire logic wr_en,
  output logic      q_full,
  output job_t      rd_job,
  output logic      q_valid,
  input  wire logic rd_en
);

  localparam int PtrW = $clog2(JOBQ_DEPTH);
  localparam int CntW = $clog2(JOBQ_DEPTH + 1);

  job_t              slots_r [JOBQ_DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;

  assign q_full  = (count_r == CntW'(JOBQ_DEPTH));
  assign q_valid = (count_r != '0);
  assign rd_job  = slots_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_en ? ((wr_ptr_r == PtrW'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1)
                       : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ((rd_ptr_r == PtrW'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1)
                       : rd_ptr_r;
    count_nxt  = count_r + CntW'(wr_en) - CntW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/otgr_back.sv -----
// ----------------------------------------------------------------------------
// otgr_back
// Byte sequencer: walks the queued character through its cursor commands
// and glyph columns, one word into the output register per cycle while it is free or popped.
// ----------------------------------------------------------------------------
`default_nettype none

module otgr_back import otgr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire job_t       job,
  input  wire logic       q_valid,
  output logic            q_pop,
  output logic [7:0]      out_byte,
  output logic            out_is_data,
  output logic            out_last,
  output logic            empty,
  input  wire logic       pop
);

  logic [3:0] pos_r, pos_nxt;
  logic       half_r, half_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       is_data_r, is_data_nxt;
  logic       last_r, last_nxt;

  logic       load;
  logic       end_of_job;
  logic       end_of_half;
  logic [3:0] dpos;
  logic [2:0] col_idx;
  logic [6:0] gcol;
  logic [3:0] nib;
  logic [7:0] stretched;
  logic [2:0] page;

  assign empty       = !out_valid_r;
  assign out_byte    = byte_r;
  assign out_is_data = is_data_r;
  assign out_last    = last_r;

  assign load = q_valid && (!out_valid_r || pop);

  // position decode
  always_comb begin
    end_of_half = job.dbl ? (pos_r == POS_LAST_DOUBLE) : (pos_r == POS_LAST_NORMAL);
    end_of_job  = end_of_half && (!job.dbl || half_r);
    dpos        = pos_r - POS_FIRST_DATA;
    col_idx     = job.dbl ? dpos[3:1] : dpos[2:0];
    gcol        = (col_idx < COL_BLANK) ? job.glyph[col_idx] : 7'h00;
    nib         = half_r ? {1'b0, gcol[6:4]} : gcol[3:0];
    page        = job.page + {2'b00, half_r};
  end

  // vertical doubling of one nibble
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      stretched[2*b]   = nib[b];
      stretched[2*b+1] = nib[b];
    end
  end

  // byte select
  always_comb begin
    is_data_nxt = 1'b1;
    case (pos_r)
      4'd0: begin
        byte_nxt    = CMD_SET_PAGE | {5'd0, page};
        is_data_nxt = 1'b0;
      end
      4'd1: begin
        byte_nxt    = CMD_SET_COL_HI | {5'd0, job.col[6:4]};
        is_data_nxt = 1'b0;
      end
      4'd2: begin
        byte_nxt    = CMD_SET_COL_LO | {4'd0, job.col[3:0]};
        is_data_nxt = 1'b0;
      end
      default: byte_nxt = job.dbl ? stretched : {1'b0, gcol};
    endcase
    last_nxt = end_of_job;
  end

  // sequencer counters and output register control
  always_comb begin
    pos_nxt       = pos_r;
    half_nxt      = half_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r;
    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      if (end_of_job) begin
        pos_nxt  = '0;
        half_nxt = 1'b0;
        q_pop    = 1'b1;
      end else if (end_of_half) begin
        pos_nxt  = '0;
        half_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= byte_nxt;
      is_data_r <= is_data_nxt;
      last_r    <= last_nxt;
    end
  end

  // sequencer checks
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST_DOUBLE)
    else $error("byte position out of range");

  a_mid_job_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != '0 || half_r) |-> q_valid)
    else $error("character in progress left the queue");

  a_half_double_only: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> job.dbl)
    else $error("second page run in normal mode");

  a_retire_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid_r && last_r))
    else $error("retired character without a final word");

endmodule

`default_nettype wire
